### sv/npl_pkg.sv
// Shared constants and types of the nibble page loader.
`default_nettype none
package npl_pkg;

  // Page geometry; the page is stored as even and odd byte banks of WORDS bytes each.
  localparam int unsigned PAGE_BYTES = 128;
  localparam int unsigned WORDS      = PAGE_BYTES / 2;
  localparam int unsigned BYTE_AW    = $clog2(PAGE_BYTES);
  localparam int unsigned WORD_AW    = $clog2(WORDS);
  localparam int unsigned FILL_W     = $clog2(PAGE_BYTES + 1);

  localparam logic [7:0] CMD_RESET    = 8'd254;
  localparam logic [7:0] THRESH_RESET = 8'd240;
  localparam logic [7:0] REPLY_RESET  = 8'(PAGE_BYTES / 16);
  localparam logic [3:0] NIB_MASK     = 4'hf;

  // Configuration register indexes, decoded from paddr[2].
  localparam int unsigned APB_AW     = 3;
  localparam logic        REG_CMD    = 1'b0;
  localparam logic        REG_THRESH = 1'b1;

  // Result kinds.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_REPLY = 2'd0;
  localparam kind_t KIND_FLASH = 2'd1;
  localparam kind_t KIND_DONE  = 2'd2;

  typedef struct packed {
    logic [7:0] command_byte;
    logic [7:0] sync_threshold;
  } cfg_t;

  typedef struct packed {
    logic               wr_en;
    logic [BYTE_AW-1:0] wr_idx;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [WORD_AW-1:0] rd_word;
  } buf_req_t;

endpackage
`default_nettype wire

### sv/npl_in_if.sv
// Input channel carrying one received link byte per word.
`default_nettype none
interface npl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

### sv/npl_out_if.sv
// Result channel carrying reply bytes and flash words.
`default_nettype none
interface npl_out_if;
  import npl_pkg::*;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [7:0]  reply_byte;
  logic [15:0] flash_addr;
  logic [15:0] flash_word;
  logic        page_start;
  logic        last;

  modport source (output valid, output kind, output reply_byte, output flash_addr,
                  output flash_word, output page_start, output last, input ready);
  modport sink (input valid, input kind, input reply_byte, input flash_addr,
                input flash_word, input page_start, input last, output ready);
endinterface
`default_nettype wire

### sv/nibble_page_loader_top.sv
// Top level of the nibble page loader: APB registers, control and page buffer.
// A word that gives one result shows it from the result register in the cycle after it is accepted.
// Throughput: one input word per cycle while the result side keeps up and no page flush runs.
// A word that completes a page or ends a partial stream flushes PAGE_BYTES/2 flash
// words, each by a buffer read and then a result load through the single buffer port.
// Reset clears all control state; buffer bytes never written read as zero.
`default_nettype none
module nibble_page_loader_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  npl_in_if.sink                          rx_i,
  npl_out_if.source                       res_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [npl_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output      logic [31:0]                prdata,
  output      logic                       pready
);
  import npl_pkg::*;

  cfg_t        cfg;
  buf_req_t    buf_req;
  logic [15:0] buf_rdata;

  npl_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  npl_page_buf u_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (buf_req),
    .rdata_o (buf_rdata)
  );

  npl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .res_o       (res_o),
    .cfg_i       (cfg),
    .buf_req_o   (buf_req),
    .buf_rdata_i (buf_rdata)
  );
endmodule
`default_nettype wire

### sv/npl_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module npl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

### sv/npl_apb_regs.sv
// APB configuration registers: command byte and sync threshold.
`default_nettype none
module npl_apb_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [npl_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output      logic [31:0]                prdata,
  output      logic                       pready,
  output      npl_pkg::cfg_t              cfg_o
);
  import npl_pkg::*;

  logic [7:0] cmd_q, cmd_d;
  logic [7:0] thresh_q, thresh_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cmd_d    = cmd_q;
    thresh_d = thresh_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_CMD:    cmd_d    = pwdata[7:0];
        REG_THRESH: thresh_d = pwdata[7:0];
        default:    cmd_d    = cmd_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CMD:    prdata = {24'd0, cmd_q};
      REG_THRESH: prdata = {24'd0, thresh_q};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= CMD_RESET;
      thresh_q <= THRESH_RESET;
    end else begin
      cmd_q    <= cmd_d;
      thresh_q <= thresh_d;
    end
  end

  assign cfg_o.command_byte   = cmd_q;
  assign cfg_o.sync_threshold = thresh_q;
endmodule
`default_nettype wire

### sv/npl_page_buf.sv
// Page buffer: even and odd byte banks read together as one 16-bit flash word.
`default_nettype none
module npl_page_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire npl_pkg::buf_req_t req_i,
  output      logic [15:0]       rdata_o
);
  import npl_pkg::*;

  logic [WORD_AW-1:0] wr_word;
  logic [WORD_AW-1:0] addr;
  logic               we_even, we_odd;
  logic [7:0]         even_rdata, odd_rdata;
  logic [WORDS-1:0]   vld_even_q, vld_odd_q;
  logic               rd_vld_even_q, rd_vld_odd_q;

  assign wr_word = req_i.wr_idx[BYTE_AW-1:1];
  assign addr    = req_i.wr_en ? wr_word : req_i.rd_word;
  assign we_even = req_i.wr_en && !req_i.wr_idx[0];
  assign we_odd  = req_i.wr_en && req_i.wr_idx[0];

  npl_ram #(.Width(8), .Depth(WORDS)) u_even (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .re_i    (req_i.rd_en),
    .addr_i  (addr),
    .wdata_i (req_i.wr_data),
    .rdata_o (even_rdata)
  );

  npl_ram #(.Width(8), .Depth(WORDS)) u_odd (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .re_i    (req_i.rd_en),
    .addr_i  (addr),
    .wdata_i (req_i.wr_data),
    .rdata_o (odd_rdata)
  );

  // Bytes never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_even_q    <= '0;
      vld_odd_q     <= '0;
      rd_vld_even_q <= 1'b0;
      rd_vld_odd_q  <= 1'b0;
    end else begin
      if (we_even) begin
        vld_even_q[wr_word] <= 1'b1;
      end
      if (we_odd) begin
        vld_odd_q[wr_word] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_even_q <= vld_even_q[req_i.rd_word];
        rd_vld_odd_q  <= vld_odd_q[req_i.rd_word];
      end
    end
  end

  assign rdata_o = {rd_vld_odd_q ? odd_rdata : 8'd0, rd_vld_even_q ? even_rdata : 8'd0};
endmodule
`default_nettype wire

### sv/npl_ctrl.sv
// Loader control: sync and nibble assembly, page flush sequencer and result register.
`default_nettype none
module npl_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  npl_in_if.sink                 rx_i,
  npl_out_if.source              res_o,
  input  wire npl_pkg::cfg_t     cfg_i,
  output      npl_pkg::buf_req_t buf_req_o,
  input  wire logic [15:0]       buf_rdata_i
);
  import npl_pkg::*;

  localparam logic [2:0] PH_SYNC       = 3'd0;
  localparam logic [2:0] PH_FIRST_HIGH = 3'd1;
  localparam logic [2:0] PH_DATA_LOW   = 3'd2;
  localparam logic [2:0] PH_DATA_HIGH  = 3'd3;
  localparam logic [2:0] PH_DONE       = 3'd4;

  localparam logic [1:0] SQ_IDLE = 2'd0;
  localparam logic [1:0] SQ_READ = 2'd1;
  localparam logic [1:0] SQ_LOAD = 2'd2;

  logic [2:0]         phase_q, phase_d;
  logic [1:0]         seq_q, seq_d;
  logic [7:0]         sync_cnt_q, sync_cnt_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [7:0]         byte_cnt_q, byte_cnt_d;
  logic [15:0]        page_base_q, page_base_d;
  logic [7:0]         reply_q, reply_d;
  logic [3:0]         lo_nib_q, lo_nib_d;
  logic [WORD_AW-1:0] word_q, word_d;

  logic               out_valid_q, out_valid_d;
  kind_t              out_kind_q, out_kind_d;
  logic [7:0]         out_reply_q, out_reply_d;
  logic [15:0]        out_addr_q, out_addr_d;
  logic [15:0]        out_word_q, out_word_d;
  logic               out_start_q, out_start_d;
  logic               out_last_q, out_last_d;

  logic               out_free;
  logic               accept;
  logic               is_cmd;
  logic [3:0]         nib;
  logic [FILL_W-1:0]  fill_inc;
  logic               last_word;
  logic               row_load;

  assign out_free  = !out_valid_q || res_o.ready;
  assign rx_i.ready = (seq_q == SQ_IDLE) && out_free;
  assign accept    = rx_i.valid && rx_i.ready;
  assign nib       = rx_i.rx_byte[3:0] & NIB_MASK;
  assign is_cmd    = rx_i.rx_byte == cfg_i.command_byte;
  assign fill_inc  = fill_q + 1'b1;
  assign last_word = word_q == WORD_AW'(WORDS - 1);
  assign row_load  = (seq_q == SQ_LOAD) && out_free;

  always_comb begin
    phase_d     = phase_q;
    seq_d       = seq_q;
    sync_cnt_d  = sync_cnt_q;
    fill_d      = fill_q;
    byte_cnt_d  = byte_cnt_q;
    page_base_d = page_base_q;
    reply_d     = reply_q;
    lo_nib_d    = lo_nib_q;
    word_d      = word_q;

    out_valid_d = out_valid_q && !res_o.ready;
    out_kind_d  = out_kind_q;
    out_reply_d = out_reply_q;
    out_addr_d  = out_addr_q;
    out_word_d  = out_word_q;
    out_start_d = out_start_q;
    out_last_d  = out_last_q;

    buf_req_o.wr_en   = 1'b0;
    buf_req_o.wr_idx  = fill_q[BYTE_AW-1:0];
    buf_req_o.wr_data = {nib, lo_nib_q};
    buf_req_o.rd_en   = 1'b0;
    buf_req_o.rd_word = word_q;

    unique case (seq_q)
      SQ_IDLE: begin
        if (accept) begin
          // A single-row result unless this byte starts a page flush.
          out_valid_d = 1'b1;
          out_kind_d  = KIND_REPLY;
          out_addr_d  = 16'd0;
          out_word_d  = 16'd0;
          out_start_d = 1'b0;
          out_last_d  = 1'b1;
          unique case (phase_q)
            PH_SYNC: begin
              reply_d = REPLY_RESET;
              if (is_cmd) begin
                if (sync_cnt_q != 8'hff) begin
                  sync_cnt_d = sync_cnt_q + 8'd1;
                end
              end else if (sync_cnt_q >= cfg_i.sync_threshold) begin
                lo_nib_d = nib;
                reply_d  = 8'd0;
                phase_d  = PH_FIRST_HIGH;
              end else begin
                sync_cnt_d = 8'd0;
              end
            end
            PH_FIRST_HIGH: begin
              buf_req_o.wr_en = 1'b1;
              fill_d          = fill_inc;
              phase_d         = PH_DATA_LOW;
            end
            PH_DATA_LOW: begin
              if (is_cmd) begin
                phase_d = PH_DONE;
                if (fill_q != '0) begin
                  out_valid_d = 1'b0;
                  seq_d       = SQ_READ;
                  word_d      = '0;
                end else begin
                  out_kind_d = KIND_DONE;
                end
              end else begin
                lo_nib_d   = nib;
                byte_cnt_d = byte_cnt_q + 8'd1;
                reply_d    = byte_cnt_q + 8'd1;
                phase_d    = PH_DATA_HIGH;
              end
            end
            PH_DATA_HIGH: begin
              buf_req_o.wr_en = 1'b1;
              fill_d          = fill_inc;
              phase_d         = PH_DATA_LOW;
              if (fill_inc == FILL_W'(PAGE_BYTES)) begin
                out_valid_d = 1'b0;
                seq_d       = SQ_READ;
                word_d      = '0;
              end
            end
            default: begin
              out_kind_d = KIND_DONE;
            end
          endcase
          out_reply_d = reply_d;
        end
      end
      SQ_READ: begin
        buf_req_o.rd_en = 1'b1;
        seq_d           = SQ_LOAD;
      end
      SQ_LOAD: begin
        if (row_load) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_FLASH;
          out_reply_d = reply_q;
          out_addr_d  = page_base_q + 16'({word_q, 1'b0});
          out_word_d  = buf_rdata_i;
          out_start_d = word_q == '0;
          out_last_d  = last_word;
          if (last_word) begin
            page_base_d = page_base_q + 16'(PAGE_BYTES);
            fill_d      = '0;
            seq_d       = SQ_IDLE;
          end else begin
            word_d = word_q + 1'b1;
            seq_d  = SQ_READ;
          end
        end
      end
      default: begin
        seq_d = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC;
      seq_q       <= SQ_IDLE;
      sync_cnt_q  <= 8'd0;
      fill_q      <= '0;
      byte_cnt_q  <= 8'd0;
      page_base_q <= 16'd0;
      reply_q     <= REPLY_RESET;
      lo_nib_q    <= 4'd0;
      word_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      seq_q       <= seq_d;
      sync_cnt_q  <= sync_cnt_d;
      fill_q      <= fill_d;
      byte_cnt_q  <= byte_cnt_d;
      page_base_q <= page_base_d;
      reply_q     <= reply_d;
      lo_nib_q    <= lo_nib_d;
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q  <= out_kind_d;
    out_reply_q <= out_reply_d;
    out_addr_q  <= out_addr_d;
    out_word_q  <= out_word_d;
    out_start_q <= out_start_d;
    out_last_q  <= out_last_d;
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.kind       = out_kind_q;
  assign res_o.reply_byte = out_reply_q;
  assign res_o.flash_addr = out_addr_q;
  assign res_o.flash_word = out_word_q;
  assign res_o.page_start = out_start_q;
  assign res_o.last       = out_last_q;

`ifndef NO_ASSERTIONS
  // A flush only runs after a full page or at the end of the stream.
  a_flush_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != SQ_IDLE) |-> (phase_q == PH_DATA_LOW || phase_q == PH_DONE))
    else $error("flush running in an unexpected phase");

  // Between items the buffer never holds a whole page.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_IDLE) |-> (fill_q < FILL_W'(PAGE_BYTES)))
    else $error("page buffer overfilled without flush");

  // Loading the last word of a page ends the flush and empties the buffer.
  a_flush_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_load && last_word) |=> (seq_q == SQ_IDLE && fill_q == '0))
    else $error("flush did not finish after its last word");

  // The first word of a page shown at the output sits at the page base.
  a_page_start_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_FLASH && out_start_q) |-> (out_addr_q == page_base_q))
    else $error("page start word not at page base");
`endif
endmodule
`default_nettype wire

### bench/npl_result_check.sv
// Result checker for the nibble page loader: tracks the configuration, predicts and compares.
module npl_result_check
  import npl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  npl_in_if                 rx_i,
  npl_out_if                res_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fail_count_o,
  output int                pending_o,
  output int                reply_count_o,
  output int                flash_count_o,
  output int                done_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    LD_SYNC,
    LD_HIGH0,
    LD_LOW,
    LD_HIGH,
    LD_DONE
  } load_phase_e;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  reply;
    logic [15:0] addr;
    logic [15:0] word;
    logic        page_start;
    logic        last;
  } loader_result_t;

  logic [7:0]     cfg_command   = CMD_RESET;
  logic [7:0]     cfg_threshold = THRESH_RESET;
  load_phase_e    phase         = LD_SYNC;
  logic [7:0]     sync_run      = 8'd0;
  logic [7:0]     page_mem [PAGE_BYTES] = '{default: 8'h00};
  int             fill          = 0;
  logic [7:0]     data_bytes    = 8'd0;
  logic [15:0]    flash_base    = 16'd0;
  logic [7:0]     reply_now     = REPLY_RESET;
  loader_result_t due_results [$];
  loader_result_t want;

  int n_fail  = 0;
  int n_reply = 0;
  int n_flash = 0;
  int n_done  = 0;

  assign fail_count_o  = n_fail;
  assign pending_o     = due_results.size();
  assign reply_count_o = n_reply;
  assign flash_count_o = n_flash;
  assign done_count_o  = n_done;

  function automatic void push_row(kind_t k, logic [15:0] a, logic [15:0] w, logic s, logic l);
    loader_result_t r;
    r.kind       = k;
    r.reply      = reply_now;
    r.addr       = a;
    r.word       = w;
    r.page_start = s;
    r.last       = l;
    due_results.push_back(r);
  endfunction

  // The whole page goes out, including stale bytes past the fill point.
  function automatic void emit_page();
    int i;
    for (i = 0; i < WORDS; i++) begin
      push_row(KIND_FLASH, flash_base + 16'(2 * i), {page_mem[2*i+1], page_mem[2*i]},
               i == 0, i == WORDS - 1);
    end
    flash_base += 16'(PAGE_BYTES);
    fill = 0;
  endfunction

  function automatic void track_rx_byte(logic [7:0] b);
    logic [3:0] nib;
    nib = b[3:0];
    case (phase)
      LD_SYNC: begin
        reply_now = REPLY_RESET;
        if (b == cfg_command) begin
          if (sync_run != 8'hff) sync_run++;
        end else if (sync_run >= cfg_threshold) begin
          page_mem[0] = {4'h0, nib};
          reply_now = 8'd0;
          phase = LD_HIGH0;
        end else begin
          sync_run = 8'd0;
        end
        push_row(KIND_REPLY, 16'd0, 16'd0, 1'b0, 1'b1);
      end
      LD_HIGH0: begin
        page_mem[0][7:4] = nib;
        fill = 1;
        phase = LD_LOW;
        push_row(KIND_REPLY, 16'd0, 16'd0, 1'b0, 1'b1);
      end
      LD_LOW: begin
        if (b == cfg_command) begin
          phase = LD_DONE;
          if (fill != 0) emit_page();
          else push_row(KIND_DONE, 16'd0, 16'd0, 1'b0, 1'b1);
        end else begin
          page_mem[fill] = {4'h0, nib};
          data_bytes++;
          reply_now = data_bytes;
          phase = LD_HIGH;
          push_row(KIND_REPLY, 16'd0, 16'd0, 1'b0, 1'b1);
        end
      end
      LD_HIGH: begin
        // A command byte in a high nibble slot is plain data.
        page_mem[fill][7:4] = nib;
        fill++;
        phase = LD_LOW;
        if (fill >= PAGE_BYTES) emit_page();
        else push_row(KIND_REPLY, 16'd0, 16'd0, 1'b0, 1'b1);
      end
      default: begin
        push_row(KIND_DONE, 16'd0, 16'd0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, got_val);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_CMD) cfg_command = pwdata[7:0];
        else cfg_threshold = pwdata[7:0];
      end
      if (res_i.valid && res_i.ready) begin
        if (due_results.size() == 0) begin
          $error("Result word with nothing expected: kind %0d", res_i.kind);
          n_fail++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", want.kind, res_i.kind);
          check_field("reply_byte", want.reply, res_i.reply_byte);
          check_field("flash_addr", want.addr, res_i.flash_addr);
          check_field("flash_word", want.word, res_i.flash_word);
          check_field("page_start", want.page_start, res_i.page_start);
          check_field("last", want.last, res_i.last);
          case (want.kind)
            KIND_FLASH: n_flash++;
            KIND_DONE:  n_done++;
            default:    n_reply++;
          endcase
        end
      end
      if (rx_i.valid && rx_i.ready) track_rx_byte(rx_i.rx_byte);
    end
  end

endmodule

### bench/tb.sv
// Testbench top of the nibble page loader: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import npl_pkg::*;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int pending;
  int reply_count;
  int flash_count;
  int done_count;

  int         n_sent     = 0;
  int         data_total = 0;
  logic [7:0] cur_cmd    = CMD_RESET;
  logic [7:0] cur_thr    = THRESH_RESET;
  bit         no_gaps    = 1'b0;

  // Sync openers under three settings; each run ends on a non-command byte.
  logic [7:0] opening_a [9] = '{8'h00, 8'hff, 8'hfe, 8'hfe, 8'hfe, 8'h7f, 8'hfe, 8'h01, 8'h80};
  logic [7:0] opening_b [6] = '{8'h00, 8'h00, 8'hfe, 8'hff, 8'h00, 8'h10};
  logic [7:0] opening_c [3] = '{8'h00, 8'hfe, 8'h5a};

  npl_in_if  rx ();
  npl_out_if res ();

  nibble_page_loader_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  npl_result_check u_result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_i          (rx),
    .res_i         (res),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .reply_count_o (reply_count),
    .flash_count_o (flash_count),
    .done_count_o  (done_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 29) == 0) no_gaps = !no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk_i); while (!rx.ready);
    @(negedge clk_i);
    n_sent++;
  endtask

  function automatic logic [7:0] other_byte();
    logic [7:0] r;
    do r = 8'($urandom); while (r == cur_cmd);
    return r;
  endfunction

  function automatic logic [7:0] high_byte();
    return ($urandom_range(0, 7) == 0) ? cur_cmd : 8'($urandom);
  endfunction

  task automatic wait_idle();
    rx.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] cmd, input logic [7:0] thr);
    wait_idle();
    write_reg(REG_CMD, cmd);
    write_reg(REG_THRESH, thr);
    cur_cmd = cmd;
    cur_thr = thr;
  endtask

  // Command runs stay below the threshold, so the loader never leaves sync here.
  task automatic sync_noise(input int n);
    int sent;
    int lim;
    int run;
    sent = 0;
    lim = (int'(cur_thr) - 1 < 10) ? int'(cur_thr) - 1 : 10;
    while (sent < n) begin
      run = $urandom_range(0, lim);
      repeat (run) push_byte(cur_cmd);
      push_byte(other_byte());
      sent += run + 1;
    end
  endtask

  // Result side: random stalls before each word, with steady stretches.
  initial begin
    res.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!res.valid);
      @(negedge clk_i);
    end
  end

  initial begin
    int k;
    rx.valid   = 1'b0;
    rx.rx_byte = 8'h00;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (opening_a[i]) push_byte(opening_a[i]);
    set_config(8'h00, 8'hff);
    foreach (opening_b[i]) push_byte(opening_b[i]);
    set_config(8'hff, 8'h01);
    foreach (opening_c[i]) push_byte(opening_c[i]);

    set_config(8'($urandom), 8'($urandom_range(2, 12)));
    sync_noise(10);
    set_config(8'($urandom), 8'($urandom_range(13, 255)));
    sync_noise(10);
    set_config(8'($urandom), 8'($urandom_range(1, 255)));
    sync_noise(10);

    // A command run at or above a small threshold opens the data stream.
    set_config(8'($urandom), 8'($urandom_range(2, 12)));
    repeat (int'(cur_thr) + $urandom_range(0, 6)) push_byte(cur_cmd);

    data_total = ($urandom_range(0, 3) == 0) ? PAGE_BYTES : PAGE_BYTES + $urandom_range(1, 8);
    push_byte(other_byte());
    push_byte(high_byte());
    for (k = 1; k < data_total; k++) begin
      push_byte(other_byte());
      push_byte(high_byte());
      if (k == PAGE_BYTES - 1) set_config(8'($urandom), 8'($urandom_range(1, 255)));
    end
    push_byte(cur_cmd);
    repeat (10) push_byte(($urandom_range(0, 2) == 0) ? cur_cmd : 8'($urandom));

    rx.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Drove %0d link bytes through sync, %0d data bytes and stream end.",
             n_sent, data_total);
    $display("Compared %0d reply words, %0d flash words and %0d finish words.",
             reply_count, flash_count, done_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
